[hw/rtl/kpc_pkg.sv]
`timescale 1ns / 1ps

package kpc_pkg;

  localparam int KEYS_MAX = 4;
  localparam int AUX_W    = 10;
  localparam int HOLD_W   = 10;
  localparam int PHASE_W  = 8;
  localparam int COUNT_W  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [HOLD_W-1:0] HOLD_MAX = '1;

  localparam logic [7:0] SHORT_MIN_RESET   = 8'd1;
  localparam logic [9:0] SHORT_MAX_RESET   = 10'd10;
  localparam logic [7:0] LONG_PERIOD_RESET = 8'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHORT_MIN   = 2'd0,
    CFG_SHORT_MAX   = 2'd1,
    CFG_LONG_PERIOD = 2'd2,
    CFG_BUZZER_SEL  = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] short_min_steps;
    logic [9:0] short_max_steps;
    logic [7:0] long_period_steps;
    logic       buzzer_via_panel;
  } cfg_t;

  typedef struct packed {
    logic [KEYS_MAX-1:0] key_released;
    logic [AUX_W-1:0]    aux_levels;
    logic                motion_alarm_load;
    logic [COUNT_W-1:0]  motion_alarm_value;
    logic                card_beep_load;
    logic [COUNT_W-1:0]  card_beep_value;
  } sample_t;

  typedef struct packed {
    logic [2*KEYS_MAX-1:0] key_events;
    logic [AUX_W-1:0]      aux_active;
    logic                  aux_changed;
    logic                  buzzer_panel_bit;
    logic                  buzzer_pin;
  } result_t;

  typedef struct packed {
    logic short_press;
    logic long_press;
  } key_flags_t;

endpackage

[hw/rtl/kpc_key_lane.sv]
`timescale 1ns / 1ps

module kpc_key_lane (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic              released,
  input  kpc_pkg::cfg_t     cfg,
  output kpc_pkg::key_flags_t flags
);

  import kpc_pkg::*;

  logic [HOLD_W-1:0]  hold_count, hold_count_next;
  logic [PHASE_W-1:0] repeat_phase, repeat_phase_next;
  key_flags_t         status, status_next;

  always_comb begin
    hold_count_next   = hold_count;
    repeat_phase_next = repeat_phase;
    status_next       = status;
    if (released) begin
      status_next.short_press = (hold_count > {2'b00, cfg.short_min_steps}) &&
                                (hold_count < cfg.short_max_steps);
      status_next.long_press  = 1'b0;
      hold_count_next         = '0;
      repeat_phase_next       = '0;
    end else begin
      if (hold_count != HOLD_MAX) begin
        hold_count_next = hold_count + 1'b1;
      end
      if (({1'b0, repeat_phase} + 9'd1) >= {1'b0, cfg.long_period_steps}) begin
        repeat_phase_next       = '0;
        status_next.short_press = 1'b0;
        status_next.long_press  = 1'b1;
      end else begin
        repeat_phase_next = repeat_phase + 1'b1;
      end
    end
  end

  assign flags = status_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_count   <= '0;
      repeat_phase <= '0;
      status       <= '0;
    end else if (accept) begin
      hold_count   <= hold_count_next;
      repeat_phase <= repeat_phase_next;
      status       <= status_next;
    end
  end

endmodule

[hw/rtl/kpc_merge.sv]
`timescale 1ns / 1ps

module kpc_merge #(
  parameter int NUM_KEYS = 4,
  parameter int NUM_AUX  = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  kpc_pkg::sample_t    sample,
  input  kpc_pkg::key_flags_t key_flags [NUM_KEYS],
  input  logic                buzzer_via_panel,
  output kpc_pkg::result_t    result_next
);

  import kpc_pkg::*;

  logic [AUX_W-1:0]      aux_previous;
  logic [AUX_W-1:0]      aux_mask;
  logic [AUX_W-1:0]      active;
  logic [COUNT_W-1:0]    motion_alarm_count, motion_alarm_count_next, motion_start;
  logic [COUNT_W-1:0]    card_beep_count, card_beep_count_next, card_start;
  logic [2*KEYS_MAX-1:0] events;
  logic                  any;

  always_comb begin
    for (int i = 0; i < AUX_W; i++) begin
      aux_mask[i] = (i < NUM_AUX);
    end
    active = ~sample.aux_levels & aux_mask;

    events = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      events[k]            = key_flags[k].short_press;
      events[k + KEYS_MAX] = key_flags[k].long_press;
    end

    motion_start = sample.motion_alarm_load ? sample.motion_alarm_value : motion_alarm_count;
    card_start   = sample.card_beep_load ? sample.card_beep_value : card_beep_count;
    motion_alarm_count_next = (motion_start != '0) ? motion_start - 1'b1 : '0;
    card_beep_count_next    = (card_start != '0) ? card_start - 1'b1 : '0;

    any = (events != '0) || (active != '0) ||
          (motion_alarm_count_next != '0) || (card_beep_count_next != '0);

    result_next.key_events       = events;
    result_next.aux_active       = active;
    result_next.aux_changed      = (active != aux_previous);
    result_next.buzzer_panel_bit = buzzer_via_panel && any;
    result_next.buzzer_pin       = !buzzer_via_panel && any;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      aux_previous       <= '0;
      motion_alarm_count <= '0;
      card_beep_count    <= '0;
    end else if (accept) begin
      aux_previous       <= active;
      motion_alarm_count <= motion_alarm_count_next;
      card_beep_count    <= card_beep_count_next;
    end
  end

endmodule

[hw/rtl/key_press_classifier_with_alarm.sv]
`timescale 1ns / 1ps

// Accepts one scan sample per clock unless stalled, giving its result next cycle from a single
// output register; a new sample is taken whenever that register is empty or being emptied,
// so sustained throughput is one sample per cycle. Each key has its own counter lane and
// the lanes are merged with the aux inputs and alarm countdowns in the same cycle.

module key_press_classifier_with_alarm #(
  parameter int NUM_KEYS = 4,
  parameter int NUM_AUX  = 10
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               sample_valid,
  output logic                               sample_stall,
  input  kpc_pkg::sample_t                   sample,
  output logic                               result_valid,
  input  logic                               result_stall,
  output kpc_pkg::result_t                   result,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [kpc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [kpc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import kpc_pkg::*;

  cfg_t       cfg;
  logic       accept;
  key_flags_t key_flags [NUM_KEYS];
  result_t    result_next;

  assign cfg_ready    = 1'b1;
  assign sample_stall = result_valid && result_stall;
  assign accept       = sample_valid && !sample_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.short_min_steps   <= SHORT_MIN_RESET;
      cfg.short_max_steps   <= SHORT_MAX_RESET;
      cfg.long_period_steps <= LONG_PERIOD_RESET;
      cfg.buzzer_via_panel  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_e'(cfg_index))
        CFG_SHORT_MIN:   cfg.short_min_steps   <= cfg_data[7:0];
        CFG_SHORT_MAX:   cfg.short_max_steps   <= cfg_data[9:0];
        CFG_LONG_PERIOD: cfg.long_period_steps <= cfg_data[7:0];
        CFG_BUZZER_SEL:  cfg.buzzer_via_panel  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    kpc_key_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .accept   (accept),
      .released (sample.key_released[k]),
      .cfg      (cfg),
      .flags    (key_flags[k])
    );
  end

  kpc_merge #(
    .NUM_KEYS (NUM_KEYS),
    .NUM_AUX  (NUM_AUX)
  ) u_merge (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .sample           (sample),
    .key_flags        (key_flags),
    .buzzer_via_panel (cfg.buzzer_via_panel),
    .result_next      (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> result_valid)
    else $error("Accepted request produced no result");

  a_one_buzzer_path: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.buzzer_panel_bit && result.buzzer_pin))
    else $error("Both buzzer paths driven");

  a_short_long_exclusive: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((result.key_events[3:0] & result.key_events[7:4]) == 4'd0))
    else $error("Key reported short and long press together");

endmodule
